// ===== hw/rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers; empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define CSC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define CSC_ASSERT_NEVER(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
    else $error("forbidden condition seen");
`else
`define CSC_ASSERT(lbl, clk, rst_n, prop)
`define CSC_ASSERT_NEVER(lbl, clk, rst_n, prop)
`endif

`endif

// ===== hw/rtl/csc_pkg.sv =====
// ---------------------------------------------------------------------------
// csc_pkg
// Types and constants of the clipped stamp compositor.
// ---------------------------------------------------------------------------
`default_nettype none

package csc_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int DEF_MAX_STAMP  = 1024;

  // wide enough for anchor +/- half stamp + column
  localparam int COORD_W = 20;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_BLANK = 2'd1,
    CMD_READ  = 2'd2,
    CMD_WRITE = 2'd3
  } csc_cmd_e;

  typedef enum logic [1:0] {
    CFG_FRAME_WIDTH     = 2'd0,
    CFG_FRAME_HEIGHT    = 2'd1,
    CFG_BLANK_THRESHOLD = 2'd2,
    CFG_UNUSED          = 2'd3
  } csc_cfg_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } csc_state_e;

  typedef struct packed {
    csc_cmd_e           cmd;
    logic               in_range;
    logic               hit;
    logic signed [31:0] val;
    logic signed [31:0] amp;
    logic signed [31:0] lvl;
  } csc_item_t;

  typedef struct packed {
    logic clearing;
    logic busy;
  } csc_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/clipped_stamp_compositor_top.sv =====
// Clipped stamp compositor.
// Input channel (in_valid_i/in_ready_o) takes one request: a stamp element
// to scale-add or blank into the frame store, or a single pixel read/write.
// Output channel (out_valid_o/out_ready_i) returns one result per request:
// the updated pixel value (zero if clipped), a clipped and a saturated flag.
// Configuration channel (cfg_valid_i/cfg_ready_o) writes frame width,
// frame height and blank threshold by index; it is always ready.
// Path: the request waits in the queue, the frame store read is registered,
// and the result is loaded into the output register. A new request is taken
// only after the previous one's read state and write/result state.
// Reset: the frame store is cleared to zero one pixel per cycle, all
// MAX_WIDTH*MAX_HEIGHT pixels; in_ready_o stays low during that pass.
// Stall: a result waits in the output register; up to two requests queue
// behind it before in_ready_o drops.
// ---------------------------------------------------------------------------
// clipped_stamp_compositor_top
// Top level: configuration registers, front, queue and back.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module clipped_stamp_compositor_top #(
  parameter int MAX_WIDTH  = csc_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = csc_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_STAMP  = csc_pkg::DEF_MAX_STAMP
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output      logic               cfg_ready_o,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [31:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  input  wire logic [1:0]         command_i,
  input  wire logic signed [15:0] anchor_x_i,
  input  wire logic signed [15:0] anchor_y_i,
  input  wire logic [10:0]        stamp_width_i,
  input  wire logic [10:0]        stamp_height_i,
  input  wire logic [9:0]         stamp_col_i,
  input  wire logic [9:0]         stamp_row_i,
  input  wire logic signed [31:0] stamp_value_i,
  input  wire logic signed [31:0] amplitude_i,
  input  wire logic signed [31:0] level_i,
  output      logic               out_valid_o,
  input  wire logic               out_ready_i,
  output      logic signed [31:0] read_data_o,
  output      logic               clipped_o,
  output      logic               saturated_o
);

  import csc_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int DW = AW + $bits(csc_item_t);

  logic [10:0]        frame_width_q, frame_height_q;
  logic signed [31:0] blank_threshold_q;
  csc_cfg_e           cfg_idx;

  logic [AW-1:0]      f_addr, h_addr;
  csc_item_t          f_item, h_item;
  logic [DW-1:0]      h_data;
  logic               q_full, q_push, q_pop, h_valid;
  csc_status_t        status;

  assign cfg_ready_o = 1'b1;
  assign cfg_idx     = csc_cfg_e'(cfg_index_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q     <= 11'd1024;
      frame_height_q    <= 11'd1024;
      blank_threshold_q <= 32'sh80000000;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx)
        CFG_FRAME_WIDTH:     frame_width_q     <= cfg_data_i[10:0];
        CFG_FRAME_HEIGHT:    frame_height_q    <= cfg_data_i[10:0];
        CFG_BLANK_THRESHOLD: blank_threshold_q <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  csc_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_STAMP  (MAX_STAMP)
  ) u_front (
    .command_i         (command_i),
    .anchor_x_i        (anchor_x_i),
    .anchor_y_i        (anchor_y_i),
    .stamp_width_i     (stamp_width_i),
    .stamp_height_i    (stamp_height_i),
    .stamp_col_i       (stamp_col_i),
    .stamp_row_i       (stamp_row_i),
    .stamp_value_i     (stamp_value_i),
    .amplitude_i       (amplitude_i),
    .level_i           (level_i),
    .frame_width_i     (frame_width_q),
    .frame_height_i    (frame_height_q),
    .blank_threshold_i (blank_threshold_q),
    .addr_o            (f_addr),
    .item_o            (f_item)
  );

  assign in_ready_o = !q_full && !status.clearing;
  assign q_push     = in_valid_i && in_ready_o;

  csc_queue #(
    .DW (DW)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_data_i  ({f_addr, f_item}),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .head_valid_o (h_valid),
    .head_data_o  (h_data)
  );

  assign h_addr = h_data[DW-1 -: AW];
  assign h_item = csc_item_t'(h_data[$bits(csc_item_t)-1:0]);

  csc_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (h_valid),
    .head_addr_i  (h_addr),
    .head_item_i  (h_item),
    .pop_o        (q_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .read_data_o  (read_data_o),
    .clipped_o    (clipped_o),
    .saturated_o  (saturated_o),
    .status_o     (status)
  );

  `CSC_ASSERT(a_clip_zero, clk_i, rst_ni, out_valid_o && clipped_o |-> read_data_o == 32'sd0 && !saturated_o)
  `CSC_ASSERT(a_sat_rails, clk_i, rst_ni, out_valid_o && saturated_o |-> read_data_o == 32'sh7fffffff || read_data_o == 32'sh80000000)
  `CSC_ASSERT_NEVER(a_no_accept_clear, clk_i, rst_ni, status.clearing && in_ready_o)
  `CSC_ASSERT_NEVER(a_no_exec_clear, clk_i, rst_ni, status.clearing && status.busy)

endmodule

`default_nettype wire

// ===== hw/rtl/csc_ram.sv =====
// ---------------------------------------------------------------------------
// csc_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module csc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hw/rtl/csc_front.sv =====
// ---------------------------------------------------------------------------
// csc_front
// Computes the target pixel of a request, clips it and classifies it.
// ---------------------------------------------------------------------------
`default_nettype none

module csc_front #(
  parameter int MAX_WIDTH  = csc_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = csc_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_STAMP  = csc_pkg::DEF_MAX_STAMP
) (
  input  wire logic [1:0]          command_i,
  input  wire logic signed [15:0]  anchor_x_i,
  input  wire logic signed [15:0]  anchor_y_i,
  input  wire logic [10:0]         stamp_width_i,
  input  wire logic [10:0]         stamp_height_i,
  input  wire logic [9:0]          stamp_col_i,
  input  wire logic [9:0]          stamp_row_i,
  input  wire logic signed [31:0]  stamp_value_i,
  input  wire logic signed [31:0]  amplitude_i,
  input  wire logic signed [31:0]  level_i,
  input  wire logic [10:0]         frame_width_i,
  input  wire logic [10:0]         frame_height_i,
  input  wire logic signed [31:0]  blank_threshold_i,
  output      logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0] addr_o,
  output      csc_pkg::csc_item_t  item_o
);

  import csc_pkg::*;

  localparam int AW   = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int XA_W = $clog2(MAX_WIDTH);
  localparam int YA_W = $clog2(MAX_HEIGHT);
  localparam int FW_W = $clog2(MAX_WIDTH + 1);
  localparam int FH_W = $clog2(MAX_HEIGHT + 1);
  localparam int SS_W = $clog2(MAX_STAMP + 1);

  csc_cmd_e                   cmd;
  logic [SS_W-1:0]            sw_c, sh_c;
  logic [FW_W-1:0]            fw_c;
  logic [FH_W-1:0]            fh_c;
  logic signed [COORD_W-1:0]  ax_s, ay_s, col_s, row_s, off_x, off_y, x, y;
  logic                       in_frame, in_stamp;

  always_comb begin
    cmd = csc_cmd_e'(command_i);

    sw_c = (32'(stamp_width_i)  > 32'(MAX_STAMP)) ? SS_W'(MAX_STAMP) : SS_W'(stamp_width_i);
    sh_c = (32'(stamp_height_i) > 32'(MAX_STAMP)) ? SS_W'(MAX_STAMP) : SS_W'(stamp_height_i);
    fw_c = (32'(frame_width_i)  > 32'(MAX_WIDTH))  ? FW_W'(MAX_WIDTH)  : FW_W'(frame_width_i);
    fh_c = (32'(frame_height_i) > 32'(MAX_HEIGHT)) ? FH_W'(MAX_HEIGHT) : FH_W'(frame_height_i);

    ax_s  = COORD_W'(anchor_x_i);
    ay_s  = COORD_W'(anchor_y_i);
    col_s = COORD_W'(stamp_col_i);
    row_s = COORD_W'(stamp_row_i);

    unique case (cmd)
      CMD_ADD: begin
        off_x = col_s - COORD_W'(sw_c >> 1);
        off_y = row_s - COORD_W'(sh_c >> 1);
      end
      CMD_BLANK: begin
        off_x = col_s;
        off_y = row_s;
      end
      default: begin
        off_x = '0;
        off_y = '0;
      end
    endcase

    x = ax_s + off_x;
    y = ay_s + off_y;

    in_frame = !x[COORD_W-1] && !y[COORD_W-1] &&
               (x < COORD_W'(fw_c)) && (y < COORD_W'(fh_c));
    in_stamp = (cmd == CMD_READ) || (cmd == CMD_WRITE) ||
               ((32'(stamp_col_i) < 32'(sw_c)) && (32'(stamp_row_i) < 32'(sh_c)));

    addr_o = AW'(AW'(y[YA_W-1:0]) * AW'(MAX_WIDTH)) + AW'(x[XA_W-1:0]);

    item_o.cmd      = cmd;
    item_o.in_range = in_frame && in_stamp;
    item_o.hit      = stamp_value_i > blank_threshold_i;
    item_o.val      = stamp_value_i;
    item_o.amp      = amplitude_i;
    item_o.lvl      = level_i;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/csc_queue.sv =====
// ---------------------------------------------------------------------------
// csc_queue
// Two-entry queue between the classifying front and the executing back.
// ---------------------------------------------------------------------------
`default_nettype none

module csc_queue #(
  parameter int DW = 32
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire logic [DW-1:0] push_data_i,
  output      logic          full_o,
  input  wire logic          pop_i,
  output      logic          head_valid_o,
  output      logic [DW-1:0] head_data_o
);

  logic [DW-1:0] slot_q [2];
  logic          wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0]    cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o       = cnt_q == 2'd2;
  assign head_valid_o = cnt_q != 2'd0;
  assign head_data_o  = slot_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/csc_back.sv =====
// ---------------------------------------------------------------------------
// csc_back
// Executes queued requests against the frame store: read, scale-add,
// blank or write, and holds the result until it is taken.
// ---------------------------------------------------------------------------
`default_nettype none

module csc_back #(
  parameter int MAX_WIDTH  = csc_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = csc_pkg::DEF_MAX_HEIGHT
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire logic                                    head_valid_i,
  input  wire logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0] head_addr_i,
  input  wire csc_pkg::csc_item_t                      head_item_i,
  output      logic                                    pop_o,
  output      logic                                    out_valid_o,
  input  wire logic                                    out_ready_i,
  output      logic signed [31:0]                      read_data_o,
  output      logic                                    clipped_o,
  output      logic                                    saturated_o,
  output      csc_pkg::csc_status_t                    status_o
);

  import csc_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  csc_state_e          state_q, state_d;
  logic [AW-1:0]       clr_q, clr_d;
  csc_item_t           cur_q;
  logic [AW-1:0]       addr_q;
  logic signed [63:0]  prod_q;
  logic                out_valid_q, out_valid_d;
  logic signed [31:0]  out_data_q;
  logic                out_clip_q, out_sat_q;

  logic                pop, load_out, we;
  logic [AW-1:0]       waddr;
  logic [31:0]         wdata, rdata;
  logic signed [31:0]  pix, new_pix;
  logic signed [47:0]  scaled;
  logic signed [48:0]  sum;
  logic                sat, upd;

  csc_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_frame (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (head_addr_i),
    .rdata_o (rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_q == AW'(DEPTH - 1)) state_d = ST_IDLE;
      ST_IDLE:  if (pop) state_d = ST_EXEC;
      ST_EXEC:  state_d = ST_IDLE;
      default:  state_d = ST_CLEAR;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    pop      = 1'b0;
    load_out = 1'b0;
    clr_d    = clr_q;
    unique case (state_q)
      ST_CLEAR: clr_d = clr_q + AW'(1);
      ST_IDLE:  pop = head_valid_i && (!out_valid_q || out_ready_i);
      ST_EXEC:  load_out = 1'b1;
      default:  clr_d = '0;
    endcase
  end

  // datapath of the execute step
  always_comb begin
    pix    = $signed(rdata);
    scaled = 48'(prod_q >>> 16);   // floor of the Q32.32 product
    sum    = 49'(pix) + 49'(scaled);
    sat    = 1'b0;
    if (sum > 49'sd2147483647) begin
      sat = 1'b1;
    end else if (sum < -49'sd2147483648) begin
      sat = 1'b1;
    end
    upd     = 1'b0;
    new_pix = pix;
    unique case (cur_q.cmd)
      CMD_ADD: begin
        upd = 1'b1;
        if (!sat) begin
          new_pix = 32'(sum);
        end else begin
          new_pix = sum[48] ? 32'sh80000000 : 32'sh7fffffff;
        end
      end
      CMD_BLANK: begin
        upd = cur_q.hit;
        if (cur_q.hit) new_pix = cur_q.lvl;
      end
      CMD_WRITE: begin
        upd     = 1'b1;
        new_pix = cur_q.lvl;
      end
      default: upd = 1'b0;
    endcase

    if (state_q == ST_CLEAR) begin
      we    = 1'b1;
      waddr = clr_q;
      wdata = '0;
    end else begin
      we    = (state_q == ST_EXEC) && cur_q.in_range && upd;
      waddr = addr_q;
      wdata = new_pix;
    end

    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      cur_q  <= head_item_i;
      addr_q <= head_addr_i;
      prod_q <= head_item_i.amp * head_item_i.val;
    end
    if (load_out) begin
      out_data_q <= cur_q.in_range ? new_pix : 32'sd0;
      out_clip_q <= !cur_q.in_range;
      out_sat_q  <= cur_q.in_range && (cur_q.cmd == CMD_ADD) && sat;
    end
  end

  assign pop_o             = pop;
  assign out_valid_o       = out_valid_q;
  assign read_data_o       = out_data_q;
  assign clipped_o         = out_clip_q;
  assign saturated_o       = out_sat_q;
  assign status_o.clearing = state_q == ST_CLEAR;
  assign status_o.busy     = state_q == ST_EXEC;

endmodule

`default_nettype wire
